// ----- sv/owik_pkg.sv -----
package owik_pkg;

    localparam int STICK_W  = 11;
    localparam int SPEED_W  = 14;
    localparam int ARM_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int WHEEL_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // |v| <= 864 * 16383 / 500 < 2^15
    localparam int VMAG_W   = 15;
    // sqrt(2)/2 in Q1.15 times a Q8.8 gain
    localparam int GAINK_W  = 31;
    localparam int WMAG_W   = 32;
    localparam int PROD_W   = WMAG_W + GAINK_W;

    localparam logic signed [STICK_W:0] DEAD_BAND = 12'sd160;

    // floor(n / 125) = (n * RECIP_125) >> RECIP_SHIFT for n < 2^22
    localparam logic [22:0] RECIP_125   = 23'd4294968;
    localparam int          RECIP_SHIFT = 29;

    localparam logic [14:0] SQRT_HALF_Q15 = 15'd23170;
    localparam int          ROUND_BIT     = 35;
    localparam int          SAT_BIT       = ROUND_BIT + VMAG_W;
    localparam logic [VMAG_W-1:0] OUT_LIMIT = 15'd32767;

    localparam logic [SPEED_W-1:0] TOP_SPEED_RESET = 14'd1000;
    localparam logic [ARM_W-1:0]   ARM_X_RESET     = 16'd1024;
    localparam logic [ARM_W-1:0]   ARM_Y_RESET     = 16'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd256;
    localparam logic [GAINK_W-1:0] GAINK_RESET     =
        GAINK_W'(GAIN_RESET) * GAINK_W'(SQRT_HALF_Q15);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_SPEED  = 2'd0,
        CFG_ARM_X      = 2'd1,
        CFG_ARM_Y      = 2'd2,
        CFG_WHEEL_GAIN = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic mul;
        logic div;
    } shape_en_t;

    typedef struct packed {
        logic abs;
        logic mul;
        logic rnd;
    } wheel_en_t;

endpackage

// ----- sv/owik_shape.sv -----
module owik_shape (
    input  logic                                 clk,
    input  owik_pkg::shape_en_t                  en,
    input  logic signed [owik_pkg::STICK_W-1:0]  stick,
    input  logic [owik_pkg::SPEED_W-1:0]         top_speed,
    output logic [owik_pkg::VMAG_W-1:0]          speed_mag,
    output logic                                 speed_neg
);

    logic signed [owik_pkg::STICK_W:0] stick_ext;
    logic signed [owik_pkg::STICK_W:0] above_ext;
    logic signed [owik_pkg::STICK_W:0] below_ext;
    logic [9:0]  excess;
    logic        is_below;

    logic [23:0] prod_reg;
    logic [23:0] prod_next;
    logic        neg0_reg;
    logic [21:0] prod_next_q;
    logic [44:0] quot_full;
    logic [owik_pkg::VMAG_W-1:0] mag_reg;
    logic [owik_pkg::VMAG_W-1:0] mag_next;
    logic        neg1_reg;

    assign stick_ext = {stick[owik_pkg::STICK_W-1], stick};
    assign above_ext = stick_ext - owik_pkg::DEAD_BAND;
    assign below_ext = -stick_ext - owik_pkg::DEAD_BAND;
    assign is_below  = stick_ext < -owik_pkg::DEAD_BAND;

    always_comb
    begin
        priority if (stick_ext > owik_pkg::DEAD_BAND)
            excess = above_ext[9:0];
        else if (is_below)
            excess = below_ext[9:0];
        else
            excess = 10'd0;
    end

    assign prod_next = {14'd0, excess} * {10'd0, top_speed};

    // divide by 500: drop two bits, then reciprocal of 125
    assign prod_next_q = prod_reg[23:2];
    assign quot_full = {23'd0, prod_next_q} * {22'd0, owik_pkg::RECIP_125};
    assign mag_next = quot_full[owik_pkg::RECIP_SHIFT +: owik_pkg::VMAG_W];

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg <= prod_next;
            neg0_reg <= is_below;
        end
        if (en.div)
        begin
            mag_reg  <= mag_next;
            neg1_reg <= neg0_reg;
        end
    end

    assign speed_mag = mag_reg;
    assign speed_neg = neg1_reg;

endmodule

// ----- sv/owik_wheel.sv -----
module owik_wheel (
    input  logic                                  clk,
    input  owik_pkg::wheel_en_t                   en,
    input  logic signed [32:0]                    common,
    input  logic signed [16:0]                    lin,
    input  logic                                  sub,
    input  logic [owik_pkg::GAINK_W-1:0]          gain_k,
    output logic signed [owik_pkg::WHEEL_W-1:0]   target
);

    logic signed [33:0] common_ext;
    logic signed [33:0] lin_ext;
    logic signed [33:0] sum;
    logic signed [33:0] sum_abs;

    logic [owik_pkg::WMAG_W-1:0] mag_reg;
    logic                        neg_a_reg;
    logic [owik_pkg::PROD_W-1:0] prod_reg;
    logic [owik_pkg::PROD_W-1:0] prod_next;
    logic                        neg_m_reg;

    logic [owik_pkg::PROD_W:0]   rounded;
    logic [owik_pkg::VMAG_W-1:0] rmag;
    logic signed [owik_pkg::WHEEL_W-1:0] target_reg;
    logic signed [owik_pkg::WHEEL_W-1:0] target_next;

    assign common_ext = {common[32], common};
    assign lin_ext    = {{5{lin[16]}}, lin, 12'd0};
    assign sum        = sub ? common_ext - lin_ext : common_ext + lin_ext;
    assign sum_abs    = sum[33] ? -sum : sum;

    assign prod_next = {{owik_pkg::GAINK_W{1'b0}}, mag_reg}
                     * {{owik_pkg::WMAG_W{1'b0}}, gain_k};

    // round half away from zero on the magnitude, then clamp
    assign rounded = {1'b0, prod_reg}
                   + ((owik_pkg::PROD_W + 1)'(1) << (owik_pkg::ROUND_BIT - 1));
    assign rmag    = (|rounded[owik_pkg::PROD_W:owik_pkg::SAT_BIT])
                   ? owik_pkg::OUT_LIMIT
                   : rounded[owik_pkg::ROUND_BIT +: owik_pkg::VMAG_W];
    assign target_next = neg_m_reg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});

    always_ff @(posedge clk)
    begin
        if (en.abs)
        begin
            mag_reg   <= sum_abs[owik_pkg::WMAG_W-1:0];
            neg_a_reg <= sum[33];
        end
        if (en.mul)
        begin
            prod_reg  <= prod_next;
            neg_m_reg <= neg_a_reg;
        end
        if (en.rnd)
        begin
            target_reg <= target_next;
        end
    end

    assign target = target_reg;

endmodule

// ----- sv/omni_wheel_inverse_kinematics.sv -----
// Channel   Direction  Handshake                 Payload
// stick     in         stick_valid/stick_ready   stick_x, stick_y, stick_rot
// wheel     out        wheel_valid/wheel_ready   wheel_front_left .. wheel_front_right
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One beat per cycle sustained while wheel_ready stays high, through the 7-stage
// pipeline (band and speed multiply, divide by 500, arm multiplies, sums,
// magnitude, gain multiply, round and clamp).
// Reset clears the stage valid bits and loads the register defaults.
// A stall at the output backs up only as far as the first empty stage.
// cfg_ready is always high.
module omni_wheel_inverse_kinematics (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   stick_valid,
    output logic                                   stick_ready,
    input  logic signed [owik_pkg::STICK_W-1:0]    stick_x,
    input  logic signed [owik_pkg::STICK_W-1:0]    stick_y,
    input  logic signed [owik_pkg::STICK_W-1:0]    stick_rot,
    output logic                                   wheel_valid,
    input  logic                                   wheel_ready,
    output logic signed [owik_pkg::WHEEL_W-1:0]    wheel_front_left,
    output logic signed [owik_pkg::WHEEL_W-1:0]    wheel_rear_left,
    output logic signed [owik_pkg::WHEEL_W-1:0]    wheel_rear_right,
    output logic signed [owik_pkg::WHEEL_W-1:0]    wheel_front_right,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [owik_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [owik_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int NSTAGE = 7;

    logic [owik_pkg::SPEED_W-1:0] top_speed_reg;
    logic [owik_pkg::ARM_W-1:0]   arm_x_reg;
    logic [owik_pkg::ARM_W-1:0]   arm_y_reg;
    logic [owik_pkg::GAIN_W-1:0]  wheel_gain_reg;
    logic [owik_pkg::GAINK_W-1:0] gain_k_reg;
    logic [owik_pkg::GAINK_W-1:0] gain_k_next;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   ready;
    logic [NSTAGE-1:0] src_valid;

    owik_pkg::shape_en_t shape_en;
    owik_pkg::wheel_en_t wheel_en;

    logic [owik_pkg::VMAG_W-1:0] vx_mag, vy_mag, w_mag;
    logic                        vx_neg, vy_neg, w_neg;

    logic [30:0]        px_reg, py_reg;
    logic               w_neg_reg;
    logic signed [15:0] vx_reg, vy_reg;
    logic signed [15:0] vx_next, vy_next;

    logic [31:0]        arm_sum;
    logic signed [32:0] common_reg, common_next;
    logic signed [16:0] ep_reg, em_reg;

    // config
    assign cfg_ready   = 1'b1;
    assign gain_k_next = owik_pkg::GAINK_W'(cfg_data)
                       * owik_pkg::GAINK_W'(owik_pkg::SQRT_HALF_Q15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_speed_reg  <= owik_pkg::TOP_SPEED_RESET;
            arm_x_reg      <= owik_pkg::ARM_X_RESET;
            arm_y_reg      <= owik_pkg::ARM_Y_RESET;
            wheel_gain_reg <= owik_pkg::GAIN_RESET;
            gain_k_reg     <= owik_pkg::GAINK_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (owik_pkg::cfg_idx_t'(cfg_index))
                owik_pkg::CFG_TOP_SPEED:  top_speed_reg <= cfg_data[owik_pkg::SPEED_W-1:0];
                owik_pkg::CFG_ARM_X:      arm_x_reg     <= cfg_data;
                owik_pkg::CFG_ARM_Y:      arm_y_reg     <= cfg_data;
                owik_pkg::CFG_WHEEL_GAIN:
                begin
                    wheel_gain_reg <= cfg_data;
                    gain_k_reg     <= gain_k_next;
                end
            endcase
        end
    end

    // stage valid chain
    assign src_valid = {valid_reg[NSTAGE-2:0], stick_valid};

    always_comb
    begin
        ready[NSTAGE] = wheel_ready;
        for (int i = NSTAGE - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        for (int i = 0; i < NSTAGE; i++)
        begin
            valid_next[i] = ready[i] ? src_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign stick_ready = ready[0];
    assign wheel_valid = valid_reg[NSTAGE-1];

    assign shape_en.mul = ready[0];
    assign shape_en.div = ready[1];
    assign wheel_en.abs = ready[4];
    assign wheel_en.mul = ready[5];
    assign wheel_en.rnd = ready[6];

    owik_shape u_shape_x (
        .clk(clk), .en(shape_en), .stick(stick_x), .top_speed(top_speed_reg),
        .speed_mag(vx_mag), .speed_neg(vx_neg)
    );
    owik_shape u_shape_y (
        .clk(clk), .en(shape_en), .stick(stick_y), .top_speed(top_speed_reg),
        .speed_mag(vy_mag), .speed_neg(vy_neg)
    );
    owik_shape u_shape_rot (
        .clk(clk), .en(shape_en), .stick(stick_rot), .top_speed(top_speed_reg),
        .speed_mag(w_mag), .speed_neg(w_neg)
    );

    // stage 2: rotation times arms
    assign vx_next = vx_neg ? -$signed({1'b0, vx_mag}) : $signed({1'b0, vx_mag});
    assign vy_next = vy_neg ? -$signed({1'b0, vy_mag}) : $signed({1'b0, vy_mag});

    // stage 3: every wheel sums w*(ax+ay) with +-vx +-vy
    assign arm_sum     = {1'b0, px_reg} + {1'b0, py_reg};
    assign common_next = w_neg_reg ? -$signed({1'b0, arm_sum}) : $signed({1'b0, arm_sum});

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            px_reg    <= {16'd0, w_mag} * {15'd0, arm_x_reg};
            py_reg    <= {16'd0, w_mag} * {15'd0, arm_y_reg};
            w_neg_reg <= w_neg;
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
        end
        if (ready[3])
        begin
            common_reg <= common_next;
            ep_reg     <= {vx_reg[15], vx_reg} + {vy_reg[15], vy_reg};
            em_reg     <= {vx_reg[15], vx_reg} - {vy_reg[15], vy_reg};
        end
    end

    owik_wheel u_wheel_fl (
        .clk(clk), .en(wheel_en), .common(common_reg), .lin(em_reg), .sub(1'b1),
        .gain_k(gain_k_reg), .target(wheel_front_left)
    );
    owik_wheel u_wheel_rl (
        .clk(clk), .en(wheel_en), .common(common_reg), .lin(ep_reg), .sub(1'b1),
        .gain_k(gain_k_reg), .target(wheel_rear_left)
    );
    owik_wheel u_wheel_rr (
        .clk(clk), .en(wheel_en), .common(common_reg), .lin(em_reg), .sub(1'b0),
        .gain_k(gain_k_reg), .target(wheel_rear_right)
    );
    owik_wheel u_wheel_fr (
        .clk(clk), .en(wheel_en), .common(common_reg), .lin(ep_reg), .sub(1'b0),
        .gain_k(gain_k_reg), .target(wheel_front_right)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        stick_valid && stick_ready |=> valid_reg[0])
        else $error("accepted beat did not enter the first stage");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !wheel_ready |-> !stick_ready)
        else $error("input taken while pipeline full and stalled");

    a_no_min_value: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid |-> wheel_front_left != 16'sh8000 && wheel_rear_left != 16'sh8000
            && wheel_rear_right != 16'sh8000 && wheel_front_right != 16'sh8000)
        else $error("wheel target outside clamp range");

    a_gain_k: assert property (@(posedge clk) disable iff (!rst_n)
        gain_k_reg == owik_pkg::GAINK_W'(wheel_gain_reg)
            * owik_pkg::GAINK_W'(owik_pkg::SQRT_HALF_Q15))
        else $error("scaled gain out of step with wheel_gain");

endmodule

// ----- dv/owik_wheel_checker.sv -----
module owik_wheel_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                stick_valid,
    input  logic                                stick_ready,
    input  logic signed [owik_pkg::STICK_W-1:0] stick_x,
    input  logic signed [owik_pkg::STICK_W-1:0] stick_y,
    input  logic signed [owik_pkg::STICK_W-1:0] stick_rot,
    input  logic                                wheel_valid,
    input  logic                                wheel_ready,
    input  logic signed [owik_pkg::WHEEL_W-1:0] wheel_front_left,
    input  logic signed [owik_pkg::WHEEL_W-1:0] wheel_rear_left,
    input  logic signed [owik_pkg::WHEEL_W-1:0] wheel_rear_right,
    input  logic signed [owik_pkg::WHEEL_W-1:0] wheel_front_right,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [owik_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [owik_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    import owik_pkg::*;

    localparam longint DEAD_ZONE     = 160;
    localparam longint SPEED_DIVISOR = 500;
    localparam longint ARM_ONE       = 4096;
    localparam longint ROOT_HALF     = 23170;
    localparam longint WHEEL_MAX     = 32767;

    typedef logic signed [WHEEL_W-1:0] wheel_t;

    typedef struct packed {
        wheel_t front_left;
        wheel_t rear_left;
        wheel_t rear_right;
        wheel_t front_right;
    } wheel_set_t;

    logic [SPEED_W-1:0] top_speed_q;
    logic [ARM_W-1:0]   arm_x_q;
    logic [ARM_W-1:0]   arm_y_q;
    logic [GAIN_W-1:0]  gain_q;
    wheel_set_t         wheel_targets_q[$];
    int                 mismatches = 0;

    // dead band, then excess * top_speed / 500 truncated toward zero
    function automatic longint shaped_speed(logic signed [STICK_W-1:0] ch);
        longint c;
        longint excess;
        c = ch;
        if (c > DEAD_ZONE)
            excess = c - DEAD_ZONE;
        else if (c < -DEAD_ZONE)
            excess = c + DEAD_ZONE;
        else
            excess = 0;
        return (excess * longint'(top_speed_q)) / SPEED_DIVISOR;
    endfunction

    function automatic wheel_t wheel_speed(longint vx, longint vy, longint w,
                                           longint rx_sign, longint ry_sign,
                                           longint cos_sign, longint sin_sign);
        longint      rx;
        longint      ry;
        longint      along;
        longint      across;
        longint      sum;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] rounded;
        rx = rx_sign * longint'(arm_x_q);
        ry = ry_sign * longint'(arm_y_q);
        along = vx * ARM_ONE - w * ry;
        across = vy * ARM_ONE + w * rx;
        sum = cos_sign * along + sin_sign * across;
        mag = (sum < 0) ? -sum : sum;
        // Q.12 * Q1.15 * Q8.8 leaves 35 fraction bits, round half away from zero
        prod = mag * 64'(ROOT_HALF) * 64'(gain_q);
        rounded = (prod + (64'd1 << 34)) >> 35;
        if (rounded > 64'(WHEEL_MAX))
            rounded = 64'(WHEEL_MAX);
        return (sum < 0) ? -wheel_t'(rounded[WHEEL_W-1:0]) : wheel_t'(rounded[WHEEL_W-1:0]);
    endfunction

    function automatic wheel_set_t predict_wheels(logic signed [STICK_W-1:0] sx,
                                                  logic signed [STICK_W-1:0] sy,
                                                  logic signed [STICK_W-1:0] sr);
        longint     vx;
        longint     vy;
        longint     w;
        wheel_set_t t;
        vx = shaped_speed(sx);
        vy = shaped_speed(sy);
        w = shaped_speed(sr);
        t.front_left  = wheel_speed(vx, vy, w,  1,  1, -1,  1);
        t.rear_left   = wheel_speed(vx, vy, w, -1,  1, -1, -1);
        t.rear_right  = wheel_speed(vx, vy, w, -1, -1,  1, -1);
        t.front_right = wheel_speed(vx, vy, w,  1, -1,  1,  1);
        return t;
    endfunction

    task automatic check_wheel(string name, wheel_t want, wheel_t got);
        if (want !== got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wheel_set_t want;
        if (!rst_n)
        begin
            top_speed_q = TOP_SPEED_RESET;
            arm_x_q = ARM_X_RESET;
            arm_y_q = ARM_Y_RESET;
            gain_q = GAIN_RESET;
            wheel_targets_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TOP_SPEED:  top_speed_q = cfg_data[SPEED_W-1:0];
                    CFG_ARM_X:      arm_x_q = cfg_data;
                    CFG_ARM_Y:      arm_y_q = cfg_data;
                    CFG_WHEEL_GAIN: gain_q = cfg_data;
                    default:        ;
                endcase
            end
            if (stick_valid && stick_ready)
                wheel_targets_q.push_back(predict_wheels(stick_x, stick_y, stick_rot));
            if (wheel_valid && wheel_ready)
            begin
                if (wheel_targets_q.size() == 0)
                begin
                    $error("wheel beat with no stick beat outstanding");
                    mismatches++;
                end
                else
                begin
                    want = wheel_targets_q.pop_front();
                    check_wheel("wheel_front_left", want.front_left, wheel_front_left);
                    check_wheel("wheel_rear_left", want.rear_left, wheel_rear_left);
                    check_wheel("wheel_rear_right", want.rear_right, wheel_rear_right);
                    check_wheel("wheel_front_right", want.front_right, wheel_front_right);
                end
            end
            pending <= wheel_targets_q.size();
        end
        fail_count <= mismatches;
    end

endmodule

// ----- dv/omni_wheel_inverse_kinematics_tb.sv -----
module omni_wheel_inverse_kinematics_tb;
    import owik_pkg::*;

    localparam int RUN_LIMIT      = 500000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 110;
    localparam int SQUEEZE_AFTER  = 400;
    localparam int SQUEEZE_CYCLES = 300;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      stick_valid = 1'b0;
    logic                      stick_ready;
    logic signed [STICK_W-1:0] stick_x = '0;
    logic signed [STICK_W-1:0] stick_y = '0;
    logic signed [STICK_W-1:0] stick_rot = '0;
    logic                      wheel_valid;
    logic                      wheel_ready = 1'b0;
    logic signed [WHEEL_W-1:0] wheel_front_left;
    logic signed [WHEEL_W-1:0] wheel_rear_left;
    logic signed [WHEEL_W-1:0] wheel_rear_right;
    logic signed [WHEEL_W-1:0] wheel_front_right;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    int                        fail_count;
    int                        pending;
    int                        cycles = 0;
    int                        wheel_beats = 0;
    bit                        no_idle = 1'b0;

    omni_wheel_inverse_kinematics i_dut (.*);

    owik_wheel_checker i_checker (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (wheel_valid && wheel_ready)
            wheel_beats <= wheel_beats + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("omni_wheel_inverse_kinematics_tb NOT OK");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_stick();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return int'($urandom_range(0, 320)) - 160;
        if (roll < 35)
        begin
            case ($urandom_range(0, 5))
                0:       return -1024;
                1:       return 1023;
                2:       return 160;
                3:       return -160;
                4:       return 161;
                default: return -161;
            endcase
        end
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    task automatic send_sticks(int x, int y, int rot);
        int gap;
        stick_valid <= 1'b1;
        stick_x <= STICK_W'(x);
        stick_y <= STICK_W'(y);
        stick_rot <= STICK_W'(rot);
        @(posedge clk);
        while (!stick_ready)
            @(posedge clk);
        gap = idle_cycles();
        if (gap > 0)
        begin
            stick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_regs(logic [CFG_DATA_W-1:0] speed, logic [CFG_DATA_W-1:0] ax,
                              logic [CFG_DATA_W-1:0] ay, logic [CFG_DATA_W-1:0] gain);
        write_reg(CFG_TOP_SPEED, speed);
        write_reg(CFG_ARM_X, ax);
        write_reg(CFG_ARM_Y, ay);
        write_reg(CFG_WHEEL_GAIN, gain);
    endtask

    task automatic drain();
        stick_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // band edges, full deflection on each channel, all channels together
    task automatic directed_sticks();
        send_sticks(0, 0, 0);
        send_sticks(160, -160, 160);
        send_sticks(-160, 160, -160);
        send_sticks(161, -161, 161);
        send_sticks(1023, 0, 0);
        send_sticks(-1024, 0, 0);
        send_sticks(0, 1023, 0);
        send_sticks(0, -1024, 0);
        send_sticks(0, 0, 1023);
        send_sticks(0, 0, -1024);
        send_sticks(1023, 1023, 1023);
        send_sticks(-1024, -1024, -1024);
    endtask

    initial
    begin : sink
        int run_len;
        int stall_len;
        bit squeezed;
        squeezed = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            // one long hold-off so the pipeline fills and stick_ready drops
            if (!squeezed && wheel_beats >= SQUEEZE_AFTER)
            begin
                squeezed = 1'b1;
                stall_len = SQUEEZE_CYCLES;
            end
            else
            begin
                stall_len = idle_cycles();
            end
            run_len = $urandom_range(1, 24);
            wheel_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (stall_len > 0)
            begin
                wheel_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int item;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_sticks();
        drain();
        // top bits of the speed word are dropped, leaving 16383
        setup_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        directed_sticks();
        drain();
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:
                    setup_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                2:
                    setup_regs(16'd16000, 16'd0, 16'hFFFF, 16'd1);
                5:
                    setup_regs(16'(TOP_SPEED_RESET), 16'(ARM_X_RESET), 16'(ARM_Y_RESET), 16'd0);
                default:
                    setup_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)),
                               $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 1023)));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (item = 0; item < PHASE_ITEMS; item++)
                send_sticks(rand_stick(), rand_stick(), rand_stick());
            drain();
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("omni_wheel_inverse_kinematics_tb OK");
        else
            $display("omni_wheel_inverse_kinematics_tb NOT OK");
        $finish;
    end

endmodule
